@@ sv/alrp_pkg.sv @@
// Shared constants and types for the audio loop recorder.
`timescale 1ns / 1ps
package alrp_pkg;
   localparam int TAPE_DEPTH = 1048576;
   localparam int ADDR_W = $clog2(TAPE_DEPTH);
   localparam int POS_W = ADDR_W + 1;
   localparam int MIN_WINDOW = 64;
   localparam int CFG_W = 21;
   localparam int IDX_W = 3;

   localparam logic [IDX_W-1:0] REG_REC_FROM_INPUT = 3'd0;
   localparam logic [IDX_W-1:0] REG_MONITOR_ON = 3'd1;
   localparam logic [IDX_W-1:0] REG_DRIVE_AMOUNT = 3'd2;
   localparam logic [IDX_W-1:0] REG_OUT_LEVEL = 3'd3;
   localparam logic [IDX_W-1:0] REG_CROP_IN = 3'd4;
   localparam logic [IDX_W-1:0] REG_CROP_OUT = 3'd5;
   localparam logic [IDX_W-1:0] REG_WINDOW_SHIFT = 3'd6;
   localparam logic [IDX_W-1:0] REG_TAPE_CAPACITY = 3'd7;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_WIN    = 8'b00000010,
      ST_READ   = 8'b00000100,
      ST_CLIP1  = 8'b00001000,
      ST_CLIP2  = 8'b00010000,
      ST_CUBE   = 8'b00100000,
      ST_WRITE  = 8'b01000000,
      ST_OUT    = 8'b10000000
   } state_type;
endpackage

@@ sv/audio_loop_record_playback_core.sv @@
// Top level of the audio loop recorder: transport, window, tape memory and output.
`timescale 1ns / 1ps
// Loop recorder core.
// Input channel req_*: one audio frame per item with play/record trigger edges.
// Result channel rsp_*: one item per input item, the scaled output sample and the
// transport state after the frame.
// Configuration: csr_we/csr_index/csr_wdata, to be written by the user only while
// the block is idle; the block itself does not enforce this. Each frame walks a
// small sequencer: triggers and window offset multiply, window clamp, tape read,
// soft clip gain, square, cube, record write-back with advance, output scaling into
// the result register. The tape is one single-port memory with a registered read.
// One frame is in flight at a time; a new frame can be taken while the previous
// result still waits in rsp_*.
// When the receiver stalls, the result holds in rsp_* and the sequencer waits
// in its last step until the result register frees; req_ready stays low meanwhile.
// Reset clears the transport, position, length and registers to their reset
// values; the tape contents are undefined until written, and only entries
// below the recorded length are ever read back.
module audio_loop_record_playback_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_play_toggle,
   input  logic req_rec_toggle,
   input  logic signed [15:0] req_left_sample,
   input  logic signed [15:0] req_right_sample,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [15:0] rsp_out_sample,
   output logic rsp_is_playing,
   output logic rsp_is_recording,
   output logic [20:0] rsp_head_position,
   output logic [20:0] rsp_tape_length,
   input  logic csr_we,
   input  logic [alrp_pkg::IDX_W-1:0] csr_index,
   input  logic [alrp_pkg::CFG_W-1:0] csr_wdata
);
   import alrp_pkg::*;

   // configuration
   logic rec_from_input_ff, monitor_on_ff;
   logic [15:0] drive_ff;
   logic [14:0] level_ff;
   logic [20:0] crop_in_ff, crop_out_ff, cap_ff;
   logic signed [15:0] shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_from_input_ff <= 1'b1;
         monitor_on_ff <= 1'b1;
         drive_ff <= '0;
         level_ff <= 15'd14746;
         crop_in_ff <= '0;
         crop_out_ff <= '0;
         shift_ff <= '0;
         cap_ff <= 21'd1048576;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_REC_FROM_INPUT: rec_from_input_ff <= csr_wdata[0];
            REG_MONITOR_ON:     monitor_on_ff <= csr_wdata[0];
            REG_DRIVE_AMOUNT:   drive_ff <= csr_wdata[15:0];
            REG_OUT_LEVEL:      level_ff <= csr_wdata[14:0];
            REG_CROP_IN:        crop_in_ff <= csr_wdata[20:0];
            REG_CROP_OUT:       crop_out_ff <= csr_wdata[20:0];
            REG_WINDOW_SHIFT:   shift_ff <= csr_wdata[15:0];
            REG_TAPE_CAPACITY:  cap_ff <= csr_wdata[20:0];
            default: ;
         endcase
      end
   end

   // tape memory
   logic signed [15:0] tape_mem [TAPE_DEPTH];
   logic signed [15:0] rd_data_ff;
   logic mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic signed [15:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) tape_mem[mem_addr] <= mem_wdata;
      rd_data_ff <= tape_mem[mem_addr];
   end

   state_type state_ff;
   logic [POS_W-1:0] pos_ff, len_ff;
   logic play_ff, rec_ff, first_ff;
   logic win_pos_ff;
   logic signed [15:0] mid_ff;
   logic signed [37:0] mov_prod_ff;       // window_shift * length
   logic [POS_W-1:0] win_in_ff, win_out_ff;
   logic signed [17:0] src_ff;            // selected source
   logic signed [37:0] prod_ff;           // source * clip gain
   logic signed [17:0] y_ff;              // gained and clamped source
   logic signed [35:0] ysq_ff;
   logic signed [53:0] cub_ff;
   logic signed [33:0] ylvl_ff;
   logic rsp_valid_ff;
   logic [POS_W-1:0] rsp_pos_ff, rsp_len_ff;
   logic rsp_play_ff, rsp_rec_ff;
   logic signed [15:0] rsp_out_ff;
   logic rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // trigger handling, combinational from the offered item
   logic t_play, t_rec, t_first, t_win_pos;
   always_comb begin
      t_play = play_ff; t_rec = rec_ff; t_first = first_ff;
      t_win_pos = 1'b0;
      if (req_play_toggle) begin
         if (play_ff) begin
            t_play = 1'b0; t_rec = 1'b0; t_first = 1'b0;
         end else if (len_ff != '0 || rec_from_input_ff) begin
            t_play = 1'b1; t_win_pos = 1'b1;
         end
      end
      if (req_rec_toggle) begin
         if (t_rec) begin
            t_rec = 1'b0; t_first = 1'b0;
         end else begin
            // window start is zero anyway when length is zero
            if (!t_play) begin
               t_play = 1'b1; t_win_pos = 1'b1;
            end
            t_rec = 1'b1;
            t_first = (len_ff == '0);
         end
      end
   end

   // averaged input, floor of the half sum
   logic signed [16:0] lr_sum;
   assign lr_sum = 17'(req_left_sample) + 17'(req_right_sample);

   logic signed [21:0] len_s;
   assign len_s = $signed({1'b0, len_ff});

   // window computation from the registered product
   logic signed [23:0] mov;
   logic signed [24:0] wi, wo, ww, lens;
   logic [POS_W-1:0] win_in_c, win_out_c;
   always_comb begin
      // truncating division toward zero by 2^15
      mov = 24'((mov_prod_ff + (mov_prod_ff[37] ? 38'sd32767 : 38'sd0)) >>> 15);
      lens = 25'(len_s);
      wi = 25'($signed({1'b0, crop_in_ff})) + 25'(mov);
      wo = 25'($signed({1'b0, crop_out_ff})) + 25'(mov);
      ww = wo - wi;
      if (ww < 25'(MIN_WINDOW)) ww = 25'(MIN_WINDOW);
      if (wi > lens - 25'(MIN_WINDOW)) wi = lens - 25'(MIN_WINDOW);
      if (wi < 25'sd0) wi = '0;
      wo = wi + ww;
      if (wo > lens) wo = lens;
      if (wo <= wi) wo = wi + 25'sd1;
      win_in_c = POS_W'(wi);
      win_out_c = POS_W'(wo);
      if (len_ff == '0) begin
         win_in_c = '0; win_out_c = '0;
      end
   end

   logic [POS_W-1:0] cap_c;
   assign cap_c = (cap_ff == '0) ? POS_W'(1) :
                  (cap_ff > 21'(TAPE_DEPTH)) ? POS_W'(TAPE_DEPTH) : cap_ff;

   // source select, tape data is valid in ST_CLIP1
   logic signed [17:0] src_sel;
   always_comb begin
      src_sel = '0;
      if (rec_ff && rec_from_input_ff) src_sel = 18'(mid_ff);
      else if (play_ff && len_ff != '0 && pos_ff < len_ff) src_sel = 18'(rd_data_ff);
      else if (!play_ff && monitor_on_ff) src_sel = 18'(mid_ff);
   end

   logic clip_on;
   assign clip_on = (drive_ff >= 16'd328);

   // clip gain 1 + 3*drive in Q3.16
   logic [18:0] gain_c;
   logic signed [19:0] gain_s;
   assign gain_c = 19'd65536 + 19'(drive_ff) * 19'd3;
   assign gain_s = $signed({1'b0, gain_c});

   logic signed [37:0] yq;
   logic signed [17:0] y_cl;
   always_comb begin
      yq = (prod_ff + (prod_ff[37] ? 38'sd65535 : 38'sd0)) >>> 16;
      if (yq > 38'sd32768) y_cl = 18'sd32768;
      else if (yq < -38'sd32768) y_cl = -18'sd32768;
      else y_cl = 18'(yq);
   end

   // cubic shape: (3*y*2^30 - y^3) / 2^31, truncated
   logic signed [63:0] cub_num;
   logic signed [17:0] clip_res;
   always_comb begin
      cub_num = (64'(y_ff) * 64'sd3 <<< 30) - 64'(cub_ff);
      clip_res = 18'((cub_num + (cub_num[63] ? 64'sh7FFFFFFF : 64'sd0)) >>> 31);
   end

   logic signed [17:0] yv_c;
   assign yv_c = clip_on ? clip_res : src_ff;

   logic signed [33:0] rec_prod;
   logic signed [15:0] rec_val;
   assign rec_prod = yv_c * 34'sd32767;
   assign rec_val = 16'((rec_prod + (rec_prod[33] ? 34'sd32767 : 34'sd0)) >>> 15);

   // output scaling: y * lvl * 28000 / 2^29, done as (y*lvl) then *28000
   logic [14:0] lvl_c;
   logic signed [15:0] lvl_s;
   assign lvl_c = (level_ff > 15'd19661) ? 15'd19661 : level_ff;
   assign lvl_s = $signed({1'b0, lvl_c});
   logic signed [49:0] o_full;
   logic signed [20:0] o_q;
   logic signed [15:0] o_sat;
   always_comb begin
      o_full = ylvl_ff * 50'sd28000;
      o_q = 21'((o_full + (o_full[49] ? 50'sh1FFFFFFF : 50'sd0)) >>> 29);
      if (o_q > 21'sd32000) o_sat = 16'sd32000;
      else if (o_q < -21'sd32000) o_sat = -16'sd32000;
      else o_sat = 16'(o_q);
   end

   // record head write, first pass or overdub
   assign mem_addr = pos_ff[ADDR_W-1:0];
   assign mem_wdata = rec_val;
   assign mem_we = (state_ff == ST_WRITE) && rec_ff &&
                   (first_ff ? (pos_ff < cap_c) : (pos_ff < len_ff));

   // length, transport and head after the record step
   logic p_play, p_rec, p_first;
   logic [POS_W-1:0] p_pos, p_len, pos_inc;
   always_comb begin
      pos_inc = pos_ff + POS_W'(1);
      p_play = play_ff; p_rec = rec_ff; p_first = first_ff;
      p_pos = pos_ff; p_len = len_ff;
      if (rec_ff && first_ff) begin
         if (pos_ff < cap_c && pos_inc > len_ff) p_len = pos_inc;
         if (pos_inc >= cap_c) begin
            p_rec = 1'b0; p_play = 1'b0; p_first = 1'b0;
         end
      end
      if (p_play) begin
         p_pos = pos_inc;
         if (!p_first && (p_pos >= win_out_ff || p_pos >= p_len)) p_pos = win_in_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0; len_ff <= '0;
         play_ff <= 1'b0; rec_ff <= 1'b0; first_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (req_valid) begin
               play_ff <= t_play; rec_ff <= t_rec; first_ff <= t_first;
               win_pos_ff <= t_win_pos;
               mid_ff <= lr_sum[16:1];
               mov_prod_ff <= shift_ff * len_s;
               state_ff <= ST_WIN;
            end
            ST_WIN: begin
               win_in_ff <= win_in_c; win_out_ff <= win_out_c;
               if (win_pos_ff) pos_ff <= win_in_c;
               state_ff <= ST_READ;
            end
            ST_READ: state_ff <= ST_CLIP1;  // tape data lands in rd_data_ff
            ST_CLIP1: begin
               src_ff <= src_sel;
               prod_ff <= src_sel * gain_s;
               state_ff <= ST_CLIP2;
            end
            ST_CLIP2: begin
               y_ff <= y_cl;
               ysq_ff <= y_cl * y_cl;
               state_ff <= ST_CUBE;
            end
            ST_CUBE: begin
               cub_ff <= ysq_ff * y_ff;
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               play_ff <= p_play; rec_ff <= p_rec; first_ff <= p_first;
               pos_ff <= p_pos; len_ff <= p_len;
               ylvl_ff <= yv_c * lvl_s;
               state_ff <= ST_OUT;
            end
            ST_OUT: if (rsp_load) begin
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_play_ff <= 1'b0; rsp_rec_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
         rsp_out_ff <= o_sat;
         rsp_play_ff <= play_ff; rsp_rec_ff <= rec_ff;
         rsp_pos_ff <= pos_ff; rsp_len_ff <= len_ff;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_out_sample = rsp_out_ff;
   assign rsp_is_playing = rsp_play_ff;
   assign rsp_is_recording = rsp_rec_ff;
   assign rsp_head_position = rsp_pos_ff;
   assign rsp_tape_length = rsp_len_ff;

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff));
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_sample) &&
      $stable(rsp_head_position) && $stable(rsp_tape_length));
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_sample <= 16'sd32000) && (rsp_out_sample >= -16'sd32000));
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tape_length <= 21'(TAPE_DEPTH));
endmodule
